### rtl/tcpmss_pkg.sv
package tcpmss_pkg;

    // Fixed header bytes (IP plus TCP) taken off the interface MTU.
    localparam int unsigned IP_TCP_HEADER_BYTES = 40;

    // Option kinds that the walk knows.
    localparam logic [7:0] KIND_END = 8'd0;
    localparam logic [7:0] KIND_NOP = 8'd1;
    localparam logic [7:0] KIND_MSS = 8'd2;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUTE_KNOWN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERFACE_MTU = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IP_OPTION_LEN = 2'd2;

    localparam int unsigned CFG_DATA_W = 16;

    typedef struct packed {
        logic [7:0] opt_byte;
        logic       first_byte;
        logic       last_byte;
        logic       syn_flag;
        logic       syn_received;
    } opt_word_t;

    typedef struct packed {
        logic        mss_updated;
        logic [15:0] new_max_segment;
        logic        stopped_early;
    } mss_word_t;

endpackage

### rtl/tcp_option_mss_parser.sv
// TCP option parser for the maximum-segment-size option.
//
// The s_ channel carries the option area of a segment, one byte per word,
// with first/last markers and the segment's SYN and SYN-received flags. For
// each segment exactly one word leaves on the m_ channel, produced by the
// input word that has last_byte set: the accepted MSS (after the MTU limit
// and the IP option length are applied) and whether the walk stopped early.
// The cfg_ port writes route_known, interface_mtu and ip_option_len; the user
// must write it only while no segment is in flight; the block does not enforce it.
//
// Throughput is one word per cycle while no final byte is held back. A word
// is captured in an input register and processed from there, where the parser
// state and the result register are updated, so a result passes through the
// input register and then the result register before it appears on m_valid.
// When the receiver stalls, the result register holds; non-final bytes keep
// flowing; only a second final byte waits in the input register, deasserting s_ready.
// Reset (aresetn low, synchronous) clears the parser state, empties both
// registers and restores the configuration defaults.
module tcp_option_mss_parser #(
    parameter int unsigned MAX_OPTION_BYTES = 40
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  tcpmss_pkg::opt_word_t                 s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output tcpmss_pkg::mss_word_t                 m_data,
    input  logic                                  cfg_wr_en,
    input  logic [tcpmss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tcpmss_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

    // Offsets run up to MAX_OPTION_BYTES, where the byte counter parks.
    localparam int unsigned OFF_W = $clog2(MAX_OPTION_BYTES + 1);
    // Wide enough for an offset plus a full length byte.
    localparam int unsigned TGT_W = 10;
    localparam logic [TGT_W-1:0] MAX_OFF = TGT_W'(MAX_OPTION_BYTES);

    typedef enum logic [1:0] {
        PH_WALK,
        PH_LEN,
        PH_STOP,
        PH_END
    } phase_t;

    // Configuration.
    logic        route_known_reg;
    logic [5:0]  ip_option_len_reg;
    logic [15:0] mtu_limit_reg;

    // Input and output stages.
    logic                  in_valid_reg;
    tcpmss_pkg::opt_word_t in_data_reg;
    logic                  out_valid_reg;
    tcpmss_pkg::mss_word_t out_data_reg;
    tcpmss_pkg::mss_word_t out_data_next;

    // Per-segment parser state.
    logic [OFF_W-1:0] byte_offset_reg,        byte_offset_next;
    logic [OFF_W-1:0] next_kind_offset_reg,   next_kind_offset_next;
    phase_t           parse_phase_reg,        parse_phase_next;
    logic [OFF_W-1:0] mss_capture_offset_reg, mss_capture_offset_next;
    logic [7:0]       mss_high_byte_reg,      mss_high_byte_next;
    logic             mss_capture_armed_reg,  mss_capture_armed_next;
    logic             mss_high_held_reg,      mss_high_held_next;
    logic             mss_found_reg,          mss_found_next;
    logic [15:0]      mss_result_reg,         mss_result_next;
    logic             walk_stopped_reg,       walk_stopped_next;

    logic advance;

    // The stored word moves on unless it is a final byte and the result
    // register is occupied and not being taken.
    assign advance = in_valid_reg && (!in_data_reg.last_byte || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // The MTU limit is worked out when the MTU is written, so that the per-byte
    // path only compares and subtracts once each.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            route_known_reg   <= 1'b0;
            mtu_limit_reg     <= 16'd1500 - 16'(tcpmss_pkg::IP_TCP_HEADER_BYTES);
            ip_option_len_reg <= 6'd0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tcpmss_pkg::CFG_ROUTE_KNOWN:   route_known_reg   <= cfg_wr_data[0];
                tcpmss_pkg::CFG_INTERFACE_MTU: begin
                    if (cfg_wr_data >= 16'(tcpmss_pkg::IP_TCP_HEADER_BYTES)) begin
                        mtu_limit_reg <= cfg_wr_data - 16'(tcpmss_pkg::IP_TCP_HEADER_BYTES);
                    end else begin
                        mtu_limit_reg <= 16'd0;
                    end
                end
                tcpmss_pkg::CFG_IP_OPTION_LEN: ip_option_len_reg <= cfg_wr_data[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [7:0]       b;
        logic [OFF_W-1:0] off;
        logic [TGT_W-1:0] off_w;
        logic [TGT_W-1:0] target;
        logic [15:0]      raw_value;
        logic [15:0]      clamped;

        b     = in_data_reg.opt_byte;
        off_w = '0;
        target = '0;

        // A first byte starts from cleared segment state.
        if (in_data_reg.first_byte) begin
            byte_offset_next        = '0;
            next_kind_offset_next   = '0;
            parse_phase_next        = PH_WALK;
            mss_capture_offset_next = '0;
            mss_high_byte_next      = '0;
            mss_capture_armed_next  = 1'b0;
            mss_high_held_next      = 1'b0;
            mss_found_next          = 1'b0;
            mss_result_next         = '0;
            walk_stopped_next       = 1'b0;
        end else begin
            byte_offset_next        = byte_offset_reg;
            next_kind_offset_next   = next_kind_offset_reg;
            parse_phase_next        = parse_phase_reg;
            mss_capture_offset_next = mss_capture_offset_reg;
            mss_high_byte_next      = mss_high_byte_reg;
            mss_capture_armed_next  = mss_capture_armed_reg;
            mss_high_held_next      = mss_high_held_reg;
            mss_found_next          = mss_found_reg;
            mss_result_next         = mss_result_reg;
            walk_stopped_next       = walk_stopped_reg;
        end

        off       = byte_offset_next;
        off_w     = TGT_W'(off);
        raw_value = {mss_high_byte_next, b};
        if (route_known_reg && raw_value > mtu_limit_reg) begin
            clamped = mtu_limit_reg;
        end else begin
            clamped = raw_value;
        end

        if (off_w < MAX_OFF) begin
            // The byte after a captured high byte completes the value.
            if (mss_high_held_next) begin
                if (clamped > 16'(ip_option_len_reg)) begin
                    mss_result_next = clamped - 16'(ip_option_len_reg);
                end else begin
                    mss_result_next = 16'd0;
                end
                mss_found_next     = 1'b1;
                mss_high_held_next = 1'b0;
            end
            if (mss_capture_armed_next && off == mss_capture_offset_next) begin
                mss_high_byte_next     = b;
                mss_high_held_next     = 1'b1;
                mss_capture_armed_next = 1'b0;
            end

            if (parse_phase_next == PH_WALK && off == next_kind_offset_next) begin
                if (b == tcpmss_pkg::KIND_NOP) begin
                    target = off_w + TGT_W'(1);
                end else if (b == tcpmss_pkg::KIND_MSS) begin
                    if (in_data_reg.syn_flag && !in_data_reg.syn_received
                        && off_w + TGT_W'(2) < MAX_OFF) begin
                        mss_capture_armed_next  = 1'b1;
                        mss_capture_offset_next = off + OFF_W'(2);
                    end
                    parse_phase_next = PH_LEN;
                end else begin
                    parse_phase_next  = PH_STOP;
                    walk_stopped_next = 1'b1;
                end
                if (b == tcpmss_pkg::KIND_NOP) begin
                    if (target >= MAX_OFF) begin
                        parse_phase_next = PH_END;
                    end else begin
                        next_kind_offset_next = OFF_W'(target);
                        parse_phase_next      = PH_WALK;
                    end
                end
            end else if (parse_phase_next == PH_LEN) begin
                if (b == tcpmss_pkg::KIND_END) begin
                    parse_phase_next  = PH_STOP;
                    walk_stopped_next = 1'b1;
                end else begin
                    // A length of one re-reads the length byte as a no-op.
                    if (b == 8'd1) begin
                        target = off_w + TGT_W'(1);
                    end else begin
                        target = off_w + TGT_W'(b) - TGT_W'(1);
                    end
                    if (target >= MAX_OFF) begin
                        parse_phase_next = PH_END;
                    end else begin
                        next_kind_offset_next = OFF_W'(target);
                        parse_phase_next      = PH_WALK;
                    end
                end
            end
            byte_offset_next = off + OFF_W'(1);
        end

        out_data_next.mss_updated     = mss_found_next;
        out_data_next.new_max_segment = mss_found_next ? mss_result_next : 16'd0;
        out_data_next.stopped_early   = walk_stopped_next;

        // The final byte closes the segment.
        if (in_data_reg.last_byte) begin
            byte_offset_next        = '0;
            next_kind_offset_next   = '0;
            parse_phase_next        = PH_WALK;
            mss_capture_offset_next = '0;
            mss_high_byte_next      = '0;
            mss_capture_armed_next  = 1'b0;
            mss_high_held_next      = 1'b0;
            mss_found_next          = 1'b0;
            mss_result_next         = '0;
            walk_stopped_next       = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg           <= 1'b0;
            out_valid_reg          <= 1'b0;
            byte_offset_reg        <= '0;
            next_kind_offset_reg   <= '0;
            parse_phase_reg        <= PH_WALK;
            mss_capture_offset_reg <= '0;
            mss_high_byte_reg      <= '0;
            mss_capture_armed_reg  <= 1'b0;
            mss_high_held_reg      <= 1'b0;
            mss_found_reg          <= 1'b0;
            mss_result_reg         <= '0;
            walk_stopped_reg       <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance && in_data_reg.last_byte) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (advance) begin
                byte_offset_reg        <= byte_offset_next;
                next_kind_offset_reg   <= next_kind_offset_next;
                parse_phase_reg        <= parse_phase_next;
                mss_capture_offset_reg <= mss_capture_offset_next;
                mss_high_byte_reg      <= mss_high_byte_next;
                mss_capture_armed_reg  <= mss_capture_armed_next;
                mss_high_held_reg      <= mss_high_held_next;
                mss_found_reg          <= mss_found_next;
                mss_result_reg         <= mss_result_next;
                walk_stopped_reg       <= walk_stopped_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance && in_data_reg.last_byte) begin
            out_data_reg <= out_data_next;
        end
    end

    // The byte counter parks at the end of the option area.
    assert property (@(posedge aclk) disable iff (!aresetn)
        TGT_W'(byte_offset_reg) <= MAX_OFF)
        else $error("byte offset ran past the option area");

    // A pending capture never lies behind the current byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mss_capture_armed_reg |-> mss_capture_offset_reg >= byte_offset_reg)
        else $error("armed MSS capture offset already passed");

    // Only a stalled final byte may hold off the input channel.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && in_data_reg.last_byte && out_valid_reg && !m_ready)
        else $error("input stalled without a blocked result");

    // A result without an accepted MSS carries a zero segment size.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.mss_updated |-> m_data.new_max_segment == 16'd0)
        else $error("segment size set without an MSS update");

endmodule

### verif/tcp_option_mss_parser_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the MSS option parser. A directed table and then
// random option areas are streamed one word at a time. Every accepted word
// is run through an in-bench walk of the option kinds, and each result word
// is compared, field by field, with the oldest predicted result.
module tcp_option_mss_parser_test;

    localparam int unsigned AREA_BYTES = 40;
    localparam int unsigned LONG_HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES = 6;
    localparam int unsigned CYCLE_LIMIT = 400000;

    // Where the kind walk stands within the option area.
    typedef enum logic [1:0] {
        SEEK_KIND,
        READ_LENGTH,
        WALK_HALTED,
        AREA_DONE
    } walk_phase_t;

    // One row of the directed table. When has_typed is set, the row's own
    // result is pushed in place of the predicted one.
    typedef struct packed {
        tcpmss_pkg::opt_word_t word;
        logic                  has_typed;
        tcpmss_pkg::mss_word_t result;
    } stim_row_t;

    localparam tcpmss_pkg::mss_word_t NO_TYPED = '0;
    localparam int unsigned DIRECTED_ROWS = 23;

    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        // Largest MSS value on a plain SYN, no route, so it passes unchanged.
        '{'{tcpmss_pkg::KIND_MSS, 1'b1, 1'b0, 1'b1, 1'b0}, 1'b0, NO_TYPED},
        '{'{8'h04,                1'b0, 1'b0, 1'b1, 1'b0}, 1'b0, NO_TYPED},
        '{'{8'hFF,                1'b0, 1'b0, 1'b1, 1'b0}, 1'b0, NO_TYPED},
        '{'{8'hFF,                1'b0, 1'b1, 1'b1, 1'b0}, 1'b1, '{1'b1, 16'hFFFF, 1'b0}},
        // A lone end kind stops the walk at once.
        '{'{tcpmss_pkg::KIND_END, 1'b1, 1'b1, 1'b1, 1'b0}, 1'b1, '{1'b0, 16'h0000, 1'b1}},
        // The largest byte is an unknown kind and stops the walk as well.
        '{'{8'hFF,                1'b1, 1'b1, 1'b1, 1'b0}, 1'b1, '{1'b0, 16'h0000, 1'b1}},
        // A SYN was already received, so the option is walked but not taken.
        '{'{tcpmss_pkg::KIND_MSS, 1'b1, 1'b0, 1'b1, 1'b1}, 1'b0, NO_TYPED},
        '{'{8'h04,                1'b0, 1'b0, 1'b1, 1'b1}, 1'b0, NO_TYPED},
        '{'{8'h05,                1'b0, 1'b0, 1'b1, 1'b1}, 1'b0, NO_TYPED},
        '{'{8'hB4,                1'b0, 1'b1, 1'b1, 1'b1}, 1'b1, '{1'b0, 16'h0000, 1'b0}},
        // A zero length stops the walk, but the value that was begun completes.
        '{'{tcpmss_pkg::KIND_MSS, 1'b1, 1'b0, 1'b1, 1'b0}, 1'b0, NO_TYPED},
        '{'{8'h00,                1'b0, 1'b0, 1'b1, 1'b0}, 1'b0, NO_TYPED},
        '{'{8'h12,                1'b0, 1'b0, 1'b1, 1'b0}, 1'b0, NO_TYPED},
        '{'{8'h34,                1'b0, 1'b1, 1'b1, 1'b0}, 1'b1, '{1'b1, 16'h1234, 1'b1}},
        // A first byte in the middle of a segment restarts the walk.
        '{'{tcpmss_pkg::KIND_MSS, 1'b1, 1'b0, 1'b1, 1'b0}, 1'b0, NO_TYPED},
        '{'{8'h04,                1'b0, 1'b0, 1'b1, 1'b0}, 1'b0, NO_TYPED},
        '{'{tcpmss_pkg::KIND_END, 1'b1, 1'b1, 1'b1, 1'b0}, 1'b1, '{1'b0, 16'h0000, 1'b1}},
        // The segment ends before the value bytes arrive, so nothing is taken.
        '{'{tcpmss_pkg::KIND_MSS, 1'b1, 1'b0, 1'b1, 1'b0}, 1'b0, NO_TYPED},
        '{'{8'h04,                1'b0, 1'b1, 1'b1, 1'b0}, 1'b1, '{1'b0, 16'h0000, 1'b0}},
        // A new segment without a first marker; its length of one is read
        // again as a no-op, and the walk then meets a no-op and an end.
        '{'{tcpmss_pkg::KIND_MSS, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_TYPED},
        '{'{8'h01,                1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_TYPED},
        '{'{tcpmss_pkg::KIND_NOP, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_TYPED},
        '{'{tcpmss_pkg::KIND_END, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b0, NO_TYPED}
    };

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              s_valid = 1'b0;
    logic                              s_ready;
    tcpmss_pkg::opt_word_t             s_data = '0;
    logic                              m_valid;
    logic                              m_ready = 1'b0;
    tcpmss_pkg::mss_word_t             m_data;
    logic                              cfg_wr_en = 1'b0;
    logic [tcpmss_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tcpmss_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;

    tcp_option_mss_parser #(
        .MAX_OPTION_BYTES(AREA_BYTES)
    ) i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Bench copy of the configuration registers, at their reset values.
    bit          limit_by_route = 1'b0;
    logic [15:0] mtu_bytes = 16'd1500;
    logic [5:0]  ip_opt_bytes = 6'd0;

    // Bench copy of the per-segment walk state.
    logic [5:0]  walk_offset = '0;
    logic [5:0]  kind_offset = '0;
    walk_phase_t walk_phase = SEEK_KIND;
    logic [5:0]  capture_offset = '0;
    logic [7:0]  held_high = '0;
    bit          capture_armed = 1'b0;
    bit          high_held = 1'b0;
    bit          value_found = 1'b0;
    logic [15:0] found_value = '0;
    bit          walk_halted = 1'b0;

    tcpmss_pkg::mss_word_t mss_expected[$];
    int unsigned fail_count = 0;
    int unsigned results_seen = 0;
    int unsigned word_count = 0;
    int unsigned cycle_count = 0;
    bit          quiet_tail = 1'b0;

    function automatic void clear_walk();
        walk_offset = '0;
        kind_offset = '0;
        walk_phase = SEEK_KIND;
        capture_offset = '0;
        held_high = '0;
        capture_armed = 1'b0;
        high_held = 1'b0;
        value_found = 1'b0;
        found_value = '0;
        walk_halted = 1'b0;
    endfunction

    // A next kind that falls outside the area ends the walk without a stop.
    function automatic void seek_kind(input int unsigned target);
        if (target >= AREA_BYTES) begin
            walk_phase = AREA_DONE;
        end else begin
            kind_offset = target[5:0];
            walk_phase = SEEK_KIND;
        end
    endfunction

    // Advances the bench walk by one option word. On a last byte it hands back
    // the result word that the segment must produce.
    task automatic parse_opt_word(input tcpmss_pkg::opt_word_t w, output bit has_result,
                                  output tcpmss_pkg::mss_word_t result);
        int unsigned off;
        int unsigned value;
        int unsigned ceiling;
        if (w.first_byte) begin
            clear_walk();
        end
        off = 32'(walk_offset);
        // Bytes past the area leave the walk untouched.
        if (off < AREA_BYTES) begin
            // The low byte completes a value, which is then limited and reduced.
            if (high_held) begin
                value = 32'({held_high, w.opt_byte});
                if (limit_by_route) begin
                    ceiling = (32'(mtu_bytes) >= tcpmss_pkg::IP_TCP_HEADER_BYTES)
                              ? 32'(mtu_bytes) - tcpmss_pkg::IP_TCP_HEADER_BYTES : 0;
                    if (value > ceiling) begin
                        value = ceiling;
                    end
                end
                value = (value > 32'(ip_opt_bytes)) ? value - 32'(ip_opt_bytes) : 0;
                found_value = value[15:0];
                value_found = 1'b1;
                high_held = 1'b0;
            end
            if (capture_armed && off == 32'(capture_offset)) begin
                held_high = w.opt_byte;
                high_held = 1'b1;
                capture_armed = 1'b0;
            end
            if (walk_phase == SEEK_KIND && off == 32'(kind_offset)) begin
                if (w.opt_byte == tcpmss_pkg::KIND_NOP) begin
                    seek_kind(off + 1);
                end else if (w.opt_byte == tcpmss_pkg::KIND_MSS) begin
                    if (w.syn_flag && !w.syn_received && off + 2 < AREA_BYTES) begin
                        capture_armed = 1'b1;
                        capture_offset = 6'(off + 2);
                    end
                    walk_phase = READ_LENGTH;
                end else begin
                    walk_phase = WALK_HALTED;
                    walk_halted = 1'b1;
                end
            end else if (walk_phase == READ_LENGTH) begin
                // A zero length halts; a length of one makes the length byte
                // itself count as a no-op.
                if (w.opt_byte == 8'd0) begin
                    walk_phase = WALK_HALTED;
                    walk_halted = 1'b1;
                end else if (w.opt_byte == 8'd1) begin
                    seek_kind(off + 1);
                end else begin
                    seek_kind(off - 1 + 32'(w.opt_byte));
                end
            end
            walk_offset = 6'(off + 1);
        end
        has_result = w.last_byte;
        result = '0;
        if (w.last_byte) begin
            result.mss_updated = value_found;
            result.new_max_segment = value_found ? found_value : 16'd0;
            result.stopped_early = walk_halted;
            clear_walk();
        end
    endtask

    // Offers one word and waits for it to be taken. Gaps come in bursts, and
    // every third stretch of 64 words runs without any.
    task automatic send_word(input tcpmss_pkg::opt_word_t w, input bit has_typed,
                             input tcpmss_pkg::mss_word_t typed_result);
        bit                    has_result;
        tcpmss_pkg::mss_word_t predicted;
        if (!quiet_tail && (word_count / 64) % 3 != 0 && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        word_count++;
        parse_opt_word(w, has_result, predicted);
        if (has_result) begin
            mss_expected.push_back(has_typed ? typed_result : predicted);
        end
    endtask

    // Waits until every predicted result has come back, then lets the
    // pipeline empty out completely.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (mss_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Writes all three registers back to back while the block is idle.
    task automatic reconfigure(input bit route, input logic [15:0] mtu,
                               input logic [5:0] ip_opts);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_index <= tcpmss_pkg::CFG_ROUTE_KNOWN;
        cfg_wr_data <= {15'd0, route};
        @(posedge aclk);
        cfg_index <= tcpmss_pkg::CFG_INTERFACE_MTU;
        cfg_wr_data <= mtu;
        @(posedge aclk);
        cfg_index <= tcpmss_pkg::CFG_IP_OPTION_LEN;
        cfg_wr_data <= {10'd0, ip_opts};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        limit_by_route = route;
        mtu_bytes = mtu;
        ip_opt_bytes = ip_opts;
    endtask

    // Streams whole random segments until the word budget is used up. Most
    // segments are well-formed option lists with random contents; the rest
    // are raw noise. Every segment ends with a last byte.
    task automatic run_random_words(input int unsigned budget);
        logic [7:0]            seg[$];
        logic [15:0]           mss_value;
        int unsigned           sent;
        int unsigned           target;
        int unsigned           kind_pick;
        int unsigned           opt_len;
        bit                    syn;
        bit                    syn_seen;
        tcpmss_pkg::opt_word_t w;
        sent = 0;
        while (sent < budget) begin
            seg.delete();
            if ($urandom_range(0, 9) < 7) begin
                // Mostly short areas, now and then one that runs past the area.
                target = ($urandom_range(0, 7) == 0) ? $urandom_range(36, 48)
                                                     : $urandom_range(1, 24);
                while (seg.size() < target) begin
                    kind_pick = $urandom_range(0, 19);
                    if (kind_pick < 6) begin
                        seg.push_back(tcpmss_pkg::KIND_NOP);
                    end else if (kind_pick < 14) begin
                        case ($urandom_range(0, 5))
                            0: mss_value = 16'h0000;
                            1: mss_value = 16'hFFFF;
                            2: mss_value = 16'($urandom_range(0, 80));
                            3: mss_value = mtu_bytes - 16'(tcpmss_pkg::IP_TCP_HEADER_BYTES)
                                           + 16'($urandom_range(0, 4)) - 16'd2;
                            default: mss_value = 16'($urandom);
                        endcase
                        seg.push_back(tcpmss_pkg::KIND_MSS);
                        seg.push_back(8'd4);
                        seg.push_back(mss_value[15:8]);
                        seg.push_back(mss_value[7:0]);
                    end else if (kind_pick < 18) begin
                        // An MSS kind with an odd length, short or far-reaching.
                        opt_len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                              : $urandom_range(0, 10);
                        seg.push_back(tcpmss_pkg::KIND_MSS);
                        seg.push_back(8'(opt_len));
                        repeat ((opt_len > 10) ? 8 : ((opt_len > 2) ? opt_len - 2 : 0)) begin
                            seg.push_back(8'($urandom));
                        end
                    end else if (kind_pick == 18) begin
                        seg.push_back(tcpmss_pkg::KIND_END);
                    end else begin
                        seg.push_back(8'($urandom_range(3, 255)));
                    end
                end
            end else begin
                repeat ($urandom_range(1, 48)) seg.push_back(8'($urandom));
            end
            syn = ($urandom_range(0, 3) != 0);
            syn_seen = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < seg.size(); i++) begin
                w.opt_byte = seg[i];
                w.first_byte = (i == 0) ? ($urandom_range(0, 9) != 0)
                                        : ($urandom_range(0, 39) == 0);
                w.last_byte = (i == seg.size() - 1) || ($urandom_range(0, 59) == 0);
                w.syn_flag = ($urandom_range(0, 19) == 0) ? !syn : syn;
                w.syn_received = ($urandom_range(0, 19) == 0) ? !syn_seen : syn_seen;
                send_word(w, 1'b0, NO_TYPED);
            end
            sent += seg.size();
        end
    endtask

    // Result side: random stall bursts, one long hold-off that lets the block
    // fill up and push back on its input, and no stalls in the final phase.
    initial begin : result_sink
        bit long_hold_done;
        long_hold_done = 1'b0;
        @(posedge aclk);
        forever begin
            if (!long_hold_done && results_seen >= 60) begin
                long_hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
            end else if (!quiet_tail && (cycle_count / 256) % 3 != 0
                         && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Compares each result word that leaves the block with the oldest
    // prediction.
    always @(posedge aclk) begin : result_check
        tcpmss_pkg::mss_word_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (mss_expected.size() == 0) begin
                $error("result word %h arrived with no prediction waiting", m_data);
                fail_count++;
            end else begin
                want = mss_expected.pop_front();
                if (m_data.mss_updated !== want.mss_updated) begin
                    $error("mss_updated: expected %0d, got %0d",
                           want.mss_updated, m_data.mss_updated);
                    fail_count++;
                end
                if (m_data.new_max_segment !== want.new_max_segment) begin
                    $error("new_max_segment: expected %0d, got %0d",
                           want.new_max_segment, m_data.new_max_segment);
                    fail_count++;
                end
                if (m_data.stopped_early !== want.stopped_early) begin
                    $error("stopped_early: expected %0d, got %0d",
                           want.stopped_early, m_data.stopped_early);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tcp_option_mss_parser: mismatch");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // The directed table runs with the reset configuration.
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            send_word(DIRECTED[i].word, DIRECTED[i].has_typed, DIRECTED[i].result);
        end
        run_random_words(260);

        // A route with a typical MTU.
        reconfigure(1'b1, 16'd1500, 6'd0);
        run_random_words(260);
        // An MTU below the header size clamps everything to zero.
        reconfigure(1'b1, 16'd0, 6'd40);
        run_random_words(220);
        // The largest MTU with the most IP option bytes.
        reconfigure(1'b1, 16'hFFFF, 6'd40);
        run_random_words(220);
        // A limit of one byte.
        reconfigure(1'b1, 16'd41, 6'd0);
        run_random_words(200);
        // No route, so only the IP option bytes are taken off.
        reconfigure(1'b0, 16'd39, 6'd40);
        run_random_words(200);

        // The last phase runs at full rate with a random setting.
        quiet_tail = 1'b1;
        reconfigure(1'($urandom_range(0, 1)), 16'($urandom_range(40, 1600)),
                    6'($urandom_range(0, 40)));
        run_random_words(300);

        drain_results();
        if (fail_count == 0) begin
            $display("tcp_option_mss_parser: match");
        end else begin
            $display("tcp_option_mss_parser: mismatch");
        end
        $finish;
    end

endmodule

### sim.f
rtl/tcpmss_pkg.sv
rtl/tcp_option_mss_parser.sv
verif/tcp_option_mss_parser_test.sv
